/* src/i128div_pkg.sv */
// shared types and constants of the 128-bit integer divider
package i128div_pkg;

    localparam int WIDE_BITS = 128;
    localparam int HALF_BITS = 64;

    // sequencer commands to the datapath
    typedef struct packed {
        logic ready;
        logic load;
        logic neg_a;
        logic neg_b;
        logic step;
        logic fix_q;
        logic fix_r;
        logic emit;
    } ctrl_t;

    // datapath status back to the sequencer
    typedef struct packed {
        logic a_neg;
        logic b_neg;
        logic b_zero;
        logic rsp_free;
    } status_t;

endpackage

/* src/i128div_if.sv */
// handshake channels of the divider: operand request and result response
interface i128div_req_if
    import i128div_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [HALF_BITS-1:0] dividend_hi;
    logic [HALF_BITS-1:0] dividend_lo;
    logic [HALF_BITS-1:0] divisor_hi;
    logic [HALF_BITS-1:0] divisor_lo;
    logic                 is_signed;

    modport source (
        output valid, dividend_hi, dividend_lo, divisor_hi, divisor_lo, is_signed,
        input  ready
    );
    modport sink (
        input  valid, dividend_hi, dividend_lo, divisor_hi, divisor_lo, is_signed,
        output ready
    );
endinterface

interface i128div_rsp_if
    import i128div_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [HALF_BITS-1:0] quotient_hi;
    logic [HALF_BITS-1:0] quotient_lo;
    logic [HALF_BITS-1:0] remainder_hi;
    logic [HALF_BITS-1:0] remainder_lo;
    logic                 divide_by_zero;

    modport source (
        output valid, quotient_hi, quotient_lo, remainder_hi, remainder_lo, divide_by_zero,
        input  ready
    );
    modport sink (
        input  valid, quotient_hi, quotient_lo, remainder_hi, remainder_lo, divide_by_zero,
        output ready
    );
endinterface

/* src/i128div_sub.sv */
// shared subtractor: trial subtract, operand negation and sign fix-up
module i128div_sub
    import i128div_pkg::*;
#(
    parameter int WIDTH = 130
) (
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    output logic [WIDTH-1:0] diff
);

    assign diff = op_a - op_b;

endmodule

/* src/i128div_seq.sv */
// sequencer: operand sign fix, one quotient bit per cycle, result sign fix, hand-off
module i128div_seq
    import i128div_pkg::*;
#(
    parameter int OPERAND_BITS = 128
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  status_t status,
    output ctrl_t   ctrl
);

    localparam int CNT_W = $clog2(OPERAND_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NEGA = 3'd1;
    localparam logic [2:0] S_NEGB = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIXQ = 3'd4;
    localparam logic [2:0] S_FIXR = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.ready = 1'b1;
                ctrl.load  = req_valid;
                if (req_valid)
                begin
                    state_next = S_NEGA;
                end
            end
            S_NEGA:
            begin
                ctrl.neg_a = status.a_neg;
                state_next = status.b_zero ? S_DONE : S_NEGB;
            end
            S_NEGB:
            begin
                ctrl.neg_b = status.b_neg;
                cnt_next   = CNT_W'(OPERAND_BITS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIXQ;
                end
            end
            S_FIXQ:
            begin
                ctrl.fix_q = status.a_neg ^ status.b_neg;
                state_next = S_FIXR;
            end
            S_FIXR:
            begin
                ctrl.fix_r = status.a_neg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                ctrl.emit = status.rsp_free;
                if (status.rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* src/int128_divider.sv */
// top level of the restoring integer divider
//
// Channels: req carries dividend and divisor as 64-bit halves plus is_signed;
// rsp carries quotient, remainder (sign of the dividend) and divide_by_zero.
// A transfer happens on a clock edge with valid and ready both high.
// Operands are OPERAND_BITS wide; bits above that are ignored on input and
// given as zero on output.
// Steps: after a req transfer the block fixes the dividend sign, then the
// divisor sign, runs OPERAND_BITS trial subtractions (one quotient bit
// each), fixes the quotient sign, then the remainder sign, and loads the
// output register; the result shows together with the return of req.ready.
// A zero divisor skips the arithmetic and goes from the dividend sign step
// straight to loading the output register.
// All of it runs on one shared subtractor under a small sequencer.
// req.ready is high only while the block is idle; a waiting result does not
// block the next transfer, but a finished item waits while the receiver stalls.
// Reset empties the output register and returns the sequencer to idle.
module int128_divider
    import i128div_pkg::*;
#(
    parameter int OPERAND_BITS = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    i128div_req_if.sink   req,
    i128div_rsp_if.source rsp
);

    localparam int N  = OPERAND_BITS;
    localparam int UW = OPERAND_BITS + 2;

    ctrl_t   ctrl;
    status_t status;

    logic [WIDE_BITS-1:0] dividend_wide;
    logic [WIDE_BITS-1:0] divisor_wide;
    logic [N-1:0]         a_in;
    logic [N-1:0]         b_in;

    logic [N-1:0] a_reg;     // dividend magnitude, then quotient
    logic [N-1:0] b_reg;
    logic [N-1:0] rem_reg;
    logic         a_neg_reg;
    logic         b_neg_reg;
    logic         bz_reg;

    logic [N-1:0] q_out_reg;
    logic [N-1:0] r_out_reg;
    logic         dbz_out_reg;
    logic         rsp_valid_reg;

    logic [UW-1:0] op_a;
    logic [UW-1:0] op_b;
    logic [UW-1:0] diff;
    logic          fits;
    logic [N-1:0]  rem_shift;

    logic [WIDE_BITS-1:0] q_wide;
    logic [WIDE_BITS-1:0] r_wide;

    assign dividend_wide = {req.dividend_hi, req.dividend_lo};
    assign divisor_wide  = {req.divisor_hi, req.divisor_lo};
    assign a_in          = dividend_wide[N-1:0];
    assign b_in          = divisor_wide[N-1:0];

    assign status.a_neg    = a_neg_reg;
    assign status.b_neg    = b_neg_reg;
    assign status.b_zero   = bz_reg;
    assign status.rsp_free = !rsp_valid_reg || rsp.ready;

    i128div_seq #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .status    (status),
        .ctrl      (ctrl)
    );

    // operand selection for the shared subtractor; negation is zero minus x
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (ctrl.step)
        begin
            op_a = {1'b0, rem_reg, a_reg[N-1]};
            op_b = {2'b00, b_reg};
        end
        else if (ctrl.neg_a || ctrl.fix_q)
        begin
            op_b = {2'b00, a_reg};
        end
        else if (ctrl.neg_b)
        begin
            op_b = {2'b00, b_reg};
        end
        else if (ctrl.fix_r)
        begin
            op_b = {2'b00, rem_reg};
        end
    end

    i128div_sub #(
        .WIDTH (UW)
    ) u_sub (
        .op_a (op_a),
        .op_b (op_b),
        .diff (diff)
    );

    // no borrow out of the trial subtract means the divisor fits
    assign fits      = !diff[UW-1];
    assign rem_shift = {rem_reg[N-2:0], a_reg[N-1]};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg     <= a_in;
            b_reg     <= b_in;
            rem_reg   <= '0;
            a_neg_reg <= req.is_signed & a_in[N-1];
            b_neg_reg <= req.is_signed & b_in[N-1];
            bz_reg    <= (b_in == '0);
        end
        else
        begin
            if (ctrl.neg_a || ctrl.fix_q)
            begin
                a_reg <= diff[N-1:0];
            end
            if (ctrl.neg_b)
            begin
                b_reg <= diff[N-1:0];
            end
            if (ctrl.fix_r)
            begin
                rem_reg <= diff[N-1:0];
            end
            if (ctrl.step)
            begin
                rem_reg <= fits ? diff[N-1:0] : rem_shift;
                a_reg   <= {a_reg[N-2:0], fits};
            end
        end
        if (ctrl.emit)
        begin
            q_out_reg   <= bz_reg ? '0 : a_reg;
            r_out_reg   <= bz_reg ? '0 : rem_reg;
            dbz_out_reg <= bz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign q_wide = WIDE_BITS'(q_out_reg);
    assign r_wide = WIDE_BITS'(r_out_reg);

    assign req.ready          = ctrl.ready;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.quotient_hi    = q_wide[WIDE_BITS-1:HALF_BITS];
    assign rsp.quotient_lo    = q_wide[HALF_BITS-1:0];
    assign rsp.remainder_hi   = r_wide[WIDE_BITS-1:HALF_BITS];
    assign rsp.remainder_lo   = r_wide[HALF_BITS-1:0];
    assign rsp.divide_by_zero = dbz_out_reg;

endmodule

/* src/i128div_check.sv */
// port-level checks of the divider and their binding to the top level
module i128div_check
    import i128div_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [HALF_BITS-1:0] quotient_hi,
    input logic [HALF_BITS-1:0] quotient_lo,
    input logic [HALF_BITS-1:0] remainder_hi,
    input logic [HALF_BITS-1:0] remainder_lo,
    input logic                 divide_by_zero
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    // one item at a time: busy straight after a request transfer
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // a new result only appears after a busy cycle
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without work");

    // zero divisor gives zero quotient and remainder
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && divide_by_zero |->
            quotient_hi == '0 && quotient_lo == '0 &&
            remainder_hi == '0 && remainder_lo == '0)
        else $error("non-zero result on division by zero");

endmodule

bind int128_divider i128div_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .quotient_hi    (rsp.quotient_hi),
    .quotient_lo    (rsp.quotient_lo),
    .remainder_hi   (rsp.remainder_hi),
    .remainder_lo   (rsp.remainder_lo),
    .divide_by_zero (rsp.divide_by_zero)
);

/* tb/int128_divider_tb.sv */
// self-checking testbench of the 128-bit restoring divider: directed corners, random operands, stalls
`timescale 1ns / 100ps

module int128_divider_tb
    import i128div_pkg::*;
;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = WIDE_BITS + 16;
    localparam int MAX_PRINTED  = 20;

    typedef logic [WIDE_BITS-1:0] wide_t;

    typedef struct packed {
        logic [HALF_BITS-1:0] quotient_hi;
        logic [HALF_BITS-1:0] quotient_lo;
        logic [HALF_BITS-1:0] remainder_hi;
        logic [HALF_BITS-1:0] remainder_lo;
        logic                 divide_by_zero;
    } div_result_t;

    localparam wide_t WIDE_MIN  = {1'b1, {(WIDE_BITS-1){1'b0}}};
    localparam wide_t WIDE_MAX  = {1'b0, {(WIDE_BITS-1){1'b1}}};
    localparam wide_t WIDE_ONES = {WIDE_BITS{1'b1}};

    class division_board;
        div_result_t expected_divisions[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // magnitudes are divided, then signs restored; negation wraps at full width
        function div_result_t predict_division(wide_t dividend, wide_t divisor, logic sgn);
            div_result_t res;
            wide_t       mag_a;
            wide_t       mag_b;
            wide_t       quo;
            wide_t       rem;
            logic        neg_a;
            logic        neg_b;
            res = '0;
            if (divisor == '0)
            begin
                res.divide_by_zero = 1'b1;
                return res;
            end
            neg_a = sgn & dividend[WIDE_BITS-1];
            neg_b = sgn & divisor[WIDE_BITS-1];
            mag_a = neg_a ? -dividend : dividend;
            mag_b = neg_b ? -divisor : divisor;
            quo   = mag_a / mag_b;
            rem   = mag_a % mag_b;
            if (neg_a != neg_b)
                quo = -quo;
            if (neg_a)
                rem = -rem;
            res.quotient_hi  = quo[WIDE_BITS-1:HALF_BITS];
            res.quotient_lo  = quo[HALF_BITS-1:0];
            res.remainder_hi = rem[WIDE_BITS-1:HALF_BITS];
            res.remainder_lo = rem[HALF_BITS-1:0];
            return res;
        endfunction

        function void note_operands(wide_t dividend, wide_t divisor, logic sgn);
            expected_divisions.push_back(predict_division(dividend, divisor, sgn));
        endfunction

        function int outstanding();
            return expected_divisions.size();
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTED)
                $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        task compare_field(string name, logic [HALF_BITS-1:0] exp_v, logic [HALF_BITS-1:0] got_v);
            if (got_v !== exp_v)
                report_mismatch($sformatf("%s expected %h got %h", name, exp_v, got_v));
        endtask

        task check_result(div_result_t got);
            div_result_t exp_r;
            if (expected_divisions.size() == 0)
            begin
                report_mismatch("result transfer with nothing outstanding");
                return;
            end
            exp_r = expected_divisions.pop_front();
            compare_field("quotient_hi", exp_r.quotient_hi, got.quotient_hi);
            compare_field("quotient_lo", exp_r.quotient_lo, got.quotient_lo);
            compare_field("remainder_hi", exp_r.remainder_hi, got.remainder_hi);
            compare_field("remainder_lo", exp_r.remainder_lo, got.remainder_lo);
            compare_field("divide_by_zero", HALF_BITS'(exp_r.divide_by_zero),
                          HALF_BITS'(got.divide_by_zero));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic results_hold_due;

    division_board board;

    i128div_req_if req();
    i128div_rsp_if rsp();

    int128_divider uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 5);
        else if (roll < 97)
            return $urandom_range(6, 40);
        return $urandom_range(41, 200);
    endfunction

    function automatic wide_t random_operand();
        wide_t v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return v;
            1: return v >> $urandom_range(1, WIDE_BITS - 1);
            2: return v >> $urandom_range(WIDE_BITS - 32, WIDE_BITS - 1);
            default: return ~(v >> $urandom_range(WIDE_BITS - 32, WIDE_BITS - 1));
        endcase
    endfunction

    function automatic wide_t corner_operand();
        case ($urandom_range(0, 5))
            0: return WIDE_MIN;
            1: return WIDE_MAX;
            2: return WIDE_ONES;
            3: return '0;
            4: return wide_t'(1);
            default: return wide_t'(2);
        endcase
    endfunction

    // called in the time step of the previous transfer edge
    task automatic send_division(wide_t dividend, wide_t divisor, logic sgn);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.dividend_hi <= dividend[WIDE_BITS-1:HALF_BITS];
        req.dividend_lo <= dividend[HALF_BITS-1:0];
        req.divisor_hi  <= divisor[WIDE_BITS-1:HALF_BITS];
        req.divisor_lo  <= divisor[HALF_BITS-1:0];
        req.is_signed   <= sgn;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic pause_until_drained(int limit);
        int waited;
        waited = 0;
        req.valid <= 1'b0;
        while (board.outstanding() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // transfer monitor: operands go to the predictor, results to the checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                board.note_operands({req.dividend_hi, req.dividend_lo},
                                    {req.divisor_hi, req.divisor_lo}, req.is_signed);
            if (rsp.valid && rsp.ready)
                board.check_result({rsp.quotient_hi, rsp.quotient_lo, rsp.remainder_hi,
                                    rsp.remainder_lo, rsp.divide_by_zero});
        end
    end

    // result receiver with random back-pressure and one long hold-off on request
    initial
    begin
        int run_len;
        int stall;
        rsp.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (results_hold_due)
            begin
                results_hold_due = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 600)
                                                       : $urandom_range(1, 20);
                stall = pick_gap();
                rsp.ready <= 1'b1;
                repeat (run_len) @(posedge clk);
                if (stall > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        wide_t a;
        wide_t b;
        logic  sgn;
        int    kind;
        board            = new();
        results_hold_due = 1'b0;
        rst_n            = 1'b0;
        req.valid       <= 1'b0;
        req.dividend_hi <= '0;
        req.dividend_lo <= '0;
        req.divisor_hi  <= '0;
        req.divisor_lo  <= '0;
        req.is_signed   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unsigned corners
        send_division(WIDE_ONES, wide_t'(1), 1'b0);
        send_division(WIDE_ONES, WIDE_ONES, 1'b0);
        send_division(wide_t'(1), WIDE_ONES, 1'b0);
        send_division('0, wide_t'(5), 1'b0);
        send_division(WIDE_MIN, WIDE_ONES, 1'b0);
        send_division(WIDE_MIN, wide_t'(3), 1'b0);
        send_division(WIDE_ONES, {64'h1, 64'h0}, 1'b0);
        send_division({64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210},
                      {64'h0, 64'hffff_ffff_0000_0001}, 1'b0);
        // zero divisor in both modes
        send_division(WIDE_ONES, '0, 1'b0);
        send_division('0, '0, 1'b1);
        send_division(WIDE_MIN, '0, 1'b1);
        // signed corners, the wrapping most negative by minus one among them
        send_division(WIDE_MIN, WIDE_ONES, 1'b1);
        send_division(WIDE_MIN, wide_t'(1), 1'b1);
        send_division(WIDE_MIN, WIDE_MIN, 1'b1);
        send_division(WIDE_MAX, WIDE_MIN, 1'b1);
        send_division(WIDE_MAX, WIDE_ONES, 1'b1);
        send_division(WIDE_ONES, WIDE_ONES, 1'b1);
        send_division(-wide_t'(7), wide_t'(2), 1'b1);
        send_division(wide_t'(7), -wide_t'(2), 1'b1);
        send_division(-wide_t'(7), -wide_t'(2), 1'b1);
        send_division(wide_t'(1), WIDE_MIN, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
                results_hold_due = 1'b1;
            if (n == 2 * RANDOM_ITEMS / 3)
                pause_until_drained(100_000);
            kind = $urandom_range(0, 99);
            sgn  = 1'($urandom_range(0, 1));
            if (kind < 4)
            begin
                a = random_operand();
                b = '0;
            end
            else if (kind < 7)
            begin
                a   = WIDE_MIN;
                b   = WIDE_ONES;
                sgn = 1'b1;
            end
            else if (kind < 12)
            begin
                a = corner_operand();
                b = corner_operand();
            end
            else
            begin
                a = random_operand();
                b = random_operand();
            end
            send_division(a, b, sgn);
        end

        pause_until_drained(200_000);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.outstanding() != 0)
            board.report_mismatch($sformatf("%0d results never arrived", board.outstanding()));

        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
